/* rtl/upq_pkg.sv */
// Shared types, codes and defaults for the unsorted-array min priority queue.
// No dependencies; imported by the queue core.
package upq_pkg;

    localparam int unsigned DEPTH_DEF    = 64;
    localparam int unsigned TAG_BITS_DEF = 32;

    localparam int unsigned TAG_PORT_W = 32;
    localparam int unsigned PRIO_W     = 32;
    localparam int unsigned REQ_W      = 3;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned COUNT_W    = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ  = 3'd0,
        REQ_DEQ  = 3'd1,
        REQ_CHG  = 3'd2,
        REQ_PEEK = 3'd3,
        REQ_CLR  = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_NOT_LOWER = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // a is more urgent than b: lower priority, then smaller tag
    function automatic logic more_urgent(
        input logic signed [PRIO_W-1:0]     prio_a,
        input logic        [TAG_PORT_W-1:0] tag_a,
        input logic signed [PRIO_W-1:0]     prio_b,
        input logic        [TAG_PORT_W-1:0] tag_b
    );
        logic res;
        if (prio_a != prio_b) begin
            res = (prio_a < prio_b);
        end else begin
            res = (tag_a < tag_b);
        end
        return res;
    endfunction

endpackage

/* rtl/upq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module upq_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/unsorted_array_min_priority_queue_core.sv */
// Top level of the unsorted-array min priority queue.
// Depends on upq_pkg and the upq_ram storage instance.
//
// Keeps up to DEPTH (tag, priority) entries in insertion order in one RAM
// with registered read data. One transaction in gives exactly one transaction
// out, carrying the found tag/priority (dequeue and peek only), a status and
// the entry count after the request. Requests are handled one at a time;
// the result sits in an output register, so the next request is accepted
// while an earlier result still waits on o_out_valid/i_out_stall.
// Work per request, from acceptance to result load, with N entries:
// enqueue, clear, or an unused code: dispatch, then done. Peek: a scan of
// all N entries for the minimum. Dequeue: the minimum scan plus the shift that
// closes the gap behind the removed entry at position k, moving the N - 1 - k
// entries above it down one (none when the removed entry is the last one).
// Change priority: a scan up to the first matching tag, or over all N
// entries when none matches.
// The single RAM read port sets the pace: one entry is read per cycle, and
// the dequeue shift writes entry i+1's data into entry i while reading i+2.
// No clearing pass is needed after reset: only entries below the count
// are ever read, and each was written first.

module unsorted_array_min_priority_queue_core
    import upq_pkg::*;
#(
    parameter int unsigned DEPTH    = DEPTH_DEF,
    parameter int unsigned TAG_BITS = TAG_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [REQ_W-1:0]             i_req_type,
    input  logic [TAG_PORT_W-1:0]        i_item_tag,
    input  logic signed [PRIO_W-1:0]     i_item_priority,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [TAG_PORT_W-1:0]        o_out_tag,
    output logic signed [PRIO_W-1:0]     o_out_priority,
    output logic [STATUS_W-1:0]          o_status,
    output logic [COUNT_W-1:0]           o_entry_count
);

    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned DW    = TAG_BITS + PRIO_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state                    r_state;
    logic [REQ_W-1:0]          r_req;
    logic [TAG_BITS-1:0]       r_tag;
    logic signed [PRIO_W-1:0]  r_prio;
    logic [CNT_W-1:0]          r_count;

    // scan / shift pointers: r_rd_idx is the next read, r_pend_idx the
    // entry whose data is on the RAM output this cycle
    logic [CNT_W-1:0]          r_rd_idx;
    logic [CNT_W-1:0]          r_pend_idx;
    logic                      r_pend;

    // running minimum
    logic [TAG_BITS-1:0]       r_best_tag;
    logic signed [PRIO_W-1:0]  r_best_prio;
    logic [CNT_W-1:0]          r_best_idx;

    // result held until the output register frees up
    logic [TAG_PORT_W-1:0]     r_res_tag;
    logic signed [PRIO_W-1:0]  r_res_prio;
    t_status                   r_res_status;

    // output register
    logic                      r_out_valid;
    logic [TAG_PORT_W-1:0]     r_out_tag;
    logic signed [PRIO_W-1:0]  r_out_prio;
    logic [STATUS_W-1:0]       r_out_status;
    logic [COUNT_W-1:0]        r_out_count;

    // RAM ports
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [DW-1:0]             mem_wdata;
    logic                      mem_re;
    logic [AW-1:0]             mem_raddr;
    logic [DW-1:0]             mem_rdata;

    logic [TAG_BITS-1:0]       d_tag;
    logic signed [PRIO_W-1:0]  d_prio;
    logic                      scan_last;
    logic                      tag_hit;
    logic                      cand_better;
    logic [TAG_BITS-1:0]       sel_tag;
    logic signed [PRIO_W-1:0]  sel_prio;
    logic [CNT_W-1:0]          sel_idx;
    logic [CNT_W-1:0]          pend_prev;
    logic                      out_free;

    upq_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign d_tag  = mem_rdata[DW-1:PRIO_W];
    assign d_prio = signed'(mem_rdata[PRIO_W-1:0]);

    assign scan_last = r_pend && (r_pend_idx == (r_count - CNT_W'(1)));
    assign tag_hit   = (d_tag == r_tag);

    // first entry seeds the minimum; strict compare keeps the earlier on a tie
    assign cand_better = (r_pend_idx == '0) ||
                         more_urgent(d_prio, TAG_PORT_W'(d_tag),
                                     r_best_prio, TAG_PORT_W'(r_best_tag));
    assign sel_tag  = cand_better ? d_tag      : r_best_tag;
    assign sel_prio = cand_better ? d_prio     : r_best_prio;
    assign sel_idx  = cand_better ? r_pend_idx : r_best_idx;

    assign pend_prev = r_pend_idx - CNT_W'(1);
    assign out_free  = !r_out_valid || !i_out_stall;

    // RAM access: one read per cycle while walking, writes from enqueue,
    // a successful priority change, or the gap-closing shift
    always_comb begin
        mem_re    = ((r_state == S_SCAN) || (r_state == S_SHIFT)) && (r_rd_idx < r_count);
        mem_raddr = r_rd_idx[AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = r_count[AW-1:0];
        mem_wdata = {r_tag, r_prio};
        if ((r_state == S_DISPATCH) && (r_req == REQ_ENQ) && (r_count != CNT_W'(DEPTH))) begin
            mem_we = 1'b1;
        end else if ((r_state == S_SCAN) && (r_req == REQ_CHG) && r_pend && tag_hit
                     && (r_prio < d_prio)) begin
            mem_we    = 1'b1;
            mem_waddr = r_pend_idx[AW-1:0];
            mem_wdata = {d_tag, r_prio};
        end else if ((r_state == S_SHIFT) && r_pend) begin
            mem_we    = 1'b1;
            mem_waddr = pend_prev[AW-1:0];
            mem_wdata = mem_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_req_type;
                        r_tag   <= i_item_tag[TAG_BITS-1:0];
                        r_prio  <= i_item_priority;
                        r_state <= S_DISPATCH;
                    end
                end

                S_DISPATCH: begin
                    r_res_tag    <= '0;
                    r_res_prio   <= '0;
                    r_res_status <= ST_OK;
                    r_rd_idx     <= '0;
                    r_pend       <= 1'b0;
                    r_state      <= S_DONE;
                    unique case (r_req) inside
                        REQ_ENQ: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                r_res_status <= ST_FULL;
                            end else begin
                                r_count <= r_count + CNT_W'(1);
                            end
                        end
                        REQ_DEQ, REQ_PEEK: begin
                            if (r_count == '0) begin
                                r_res_status <= ST_EMPTY;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                        REQ_CHG: begin
                            if (r_count == '0) begin
                                r_res_status <= ST_NOT_FOUND;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                        REQ_CLR: begin
                            r_count <= '0;
                        end
                        default: begin
                            // unused codes: no change, status ok
                        end
                    endcase
                end

                S_SCAN: begin
                    r_pend     <= mem_re;
                    r_pend_idx <= r_rd_idx;
                    if (mem_re) begin
                        r_rd_idx <= r_rd_idx + CNT_W'(1);
                    end
                    if (r_pend) begin
                        if (r_req == REQ_CHG) begin
                            if (tag_hit) begin
                                r_res_status <= (r_prio < d_prio) ? ST_OK : ST_NOT_LOWER;
                                r_state      <= S_DONE;
                            end else if (scan_last) begin
                                r_res_status <= ST_NOT_FOUND;
                                r_state      <= S_DONE;
                            end
                        end else begin
                            r_best_tag  <= sel_tag;
                            r_best_prio <= sel_prio;
                            r_best_idx  <= sel_idx;
                            if (scan_last) begin
                                r_res_tag  <= TAG_PORT_W'(sel_tag);
                                r_res_prio <= sel_prio;
                                if (r_req == REQ_PEEK) begin
                                    r_state <= S_DONE;
                                end else begin
                                    // close the gap: move entries above the minimum down one
                                    r_rd_idx <= sel_idx + CNT_W'(1);
                                    r_pend   <= 1'b0;
                                    r_state  <= S_SHIFT;
                                end
                            end
                        end
                    end
                end

                S_SHIFT: begin
                    r_pend     <= mem_re;
                    r_pend_idx <= r_rd_idx;
                    if (mem_re) begin
                        r_rd_idx <= r_rd_idx + CNT_W'(1);
                    end
                    if (!mem_re && !r_pend) begin
                        r_count <= r_count - CNT_W'(1);
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_tag    <= r_res_tag;
                        r_out_prio   <= r_res_prio;
                        r_out_status <= r_res_status;
                        r_out_count  <= COUNT_W'(r_count);
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_out_tag      = r_out_tag;
    assign o_out_priority = r_out_prio;
    assign o_status       = r_out_status;
    assign o_entry_count  = r_out_count;

`ifndef SYNTH
    // the fill count never runs past the store
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    // only an enqueue writes at or beyond the current count
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we && (r_state != S_DISPATCH) |-> CNT_W'(mem_waddr) < r_count)
        else $error("store write outside the live entries");

    // a new result is only loaded out of the finishing state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(r_out_valid && i_out_stall) && r_out_valid |-> $past(r_state) == S_DONE)
        else $error("result appeared without a finished request");

    // an empty report always goes out with a zero count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status == ST_EMPTY) |-> r_out_count == '0)
        else $error("empty status with nonzero count");
`endif

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for unsorted_array_min_priority_queue_core.
// Directed and random request streams are scored against an in-bench queue model.
// Depends on upq_pkg, the core RTL and upq_ram; needs no other files.
module tb_top
    import upq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH          = DEPTH_DEF;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    // longest single request is a full-depth dequeue
    localparam int unsigned TAIL_CYCLES    = 2 * DEPTH + 40;
    localparam int unsigned MAX_REPORTS    = 10;

    localparam logic [63:0]                 TAG_MASK_W   = (64'd1 << TAG_BITS_DEF) - 64'd1;
    localparam logic [TAG_PORT_W-1:0]       TAG_ALL_ONES = {TAG_PORT_W{1'b1}};
    localparam logic signed [PRIO_W-1:0]    PRIO_MIN     = {1'b1, {(PRIO_W-1){1'b0}}};
    localparam logic signed [PRIO_W-1:0]    PRIO_MAX     = {1'b0, {(PRIO_W-1){1'b1}}};
    // request codes past clear are not decoded; the core just echoes the count
    localparam logic [REQ_W-1:0]            REQ_SPARE_FIRST = REQ_W'(REQ_CLR + 1);
    localparam logic [REQ_W-1:0]            REQ_SPARE_LAST  = {REQ_W{1'b1}};

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic                       i_clk           = 1'b0;
    logic                       i_rst_n         = 1'b0;
    logic                       i_in_valid      = 1'b0;
    logic                       o_in_stall;
    logic [REQ_W-1:0]           i_req_type      = '0;
    logic [TAG_PORT_W-1:0]      i_item_tag      = '0;
    logic signed [PRIO_W-1:0]   i_item_priority = '0;
    logic                       o_out_valid;
    logic                       i_out_stall     = 1'b0;
    logic [TAG_PORT_W-1:0]      o_out_tag;
    logic signed [PRIO_W-1:0]   o_out_priority;
    logic [STATUS_W-1:0]        o_status;
    logic [COUNT_W-1:0]         o_entry_count;

    unsorted_array_min_priority_queue_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_item_tag      (i_item_tag),
        .i_item_priority (i_item_priority),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_tag       (o_out_tag),
        .o_out_priority  (o_out_priority),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Queue model: entries kept in insertion order, same as the core
    // ------------------------------------------------------------------
    typedef struct {
        logic [TAG_PORT_W-1:0]      tag;
        logic signed [PRIO_W-1:0]   prio;
        t_status                    status;
        logic [COUNT_W-1:0]         count;
    } t_reply;

    logic [TAG_PORT_W-1:0]      pq_tag  [DEPTH];
    logic signed [PRIO_W-1:0]   pq_prio [DEPTH];
    int unsigned                pq_count = 0;

    t_reply         replies_due[$];     // one per accepted request, oldest first
    int unsigned    mismatches   = 0;
    bit             idling       = 1'b0; // random gaps/stalls enabled
    int unsigned    stall_left   = 0;
    int unsigned    quiet_cycles = 0;

    // Apply one request to the model and return the reply the core owes.
    function automatic t_reply pq_model_apply(input logic [REQ_W-1:0]         req,
                                              input logic [TAG_PORT_W-1:0]    tag_in,
                                              input logic signed [PRIO_W-1:0] prio_in);
        t_reply                 r;
        logic [TAG_PORT_W-1:0]  tag;
        int unsigned            best;
        bit                     hit;
        tag      = tag_in & TAG_MASK_W[TAG_PORT_W-1:0];
        r.tag    = '0;
        r.prio   = '0;
        r.status = ST_OK;
        hit      = 1'b0;
        best     = 0;
        case (req)
            REQ_ENQ: begin
                if (pq_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pq_tag[pq_count]  = tag;
                    pq_prio[pq_count] = prio_in;
                    pq_count++;
                end
            end
            REQ_DEQ, REQ_PEEK: begin
                if (pq_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // lowest priority, then smaller tag; strict compare keeps the earliest
                    for (int unsigned i = 1; i < pq_count; i++) begin
                        if (pq_prio[i] < pq_prio[best] ||
                            (pq_prio[i] == pq_prio[best] && pq_tag[i] < pq_tag[best])) begin
                            best = i;
                        end
                    end
                    r.tag  = pq_tag[best];
                    r.prio = pq_prio[best];
                    if (req == REQ_DEQ) begin
                        for (int unsigned i = best; i + 1 < pq_count; i++) begin
                            pq_tag[i]  = pq_tag[i+1];
                            pq_prio[i] = pq_prio[i+1];
                        end
                        pq_count--;
                    end
                end
            end
            REQ_CHG: begin
                r.status = ST_NOT_FOUND;
                for (int unsigned i = 0; i < pq_count; i++) begin
                    if (!hit && pq_tag[i] == tag) begin
                        hit = 1'b1;
                        if (prio_in < pq_prio[i]) begin
                            pq_prio[i] = prio_in;
                            r.status   = ST_OK;
                        end else begin
                            r.status   = ST_NOT_LOWER;
                        end
                    end
                end
            end
            REQ_CLR: begin
                pq_count = 0;
            end
            default: begin
            end
        endcase
        r.count = pq_count[COUNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random field pickers, biased toward collisions and extremes
    // ------------------------------------------------------------------
    function automatic logic [TAG_PORT_W-1:0] rand_tag();
        logic [TAG_PORT_W-1:0] t;
        case ($urandom_range(0, 4))
            0: t = $urandom();
            1: t = $urandom_range(0, 7);               // small pool: ties and repeats
            2: t = (pq_count != 0) ? pq_tag[$urandom_range(0, pq_count - 1)] : $urandom();
            3: t = $urandom_range(0, 1) ? TAG_ALL_ONES : '0;
            default: begin
                t = '0;
                t[$urandom_range(0, TAG_PORT_W - 1)] = 1'b1;
                if ($urandom_range(0, 1)) t = ~t;
            end
        endcase
        return t;
    endfunction

    function automatic logic signed [PRIO_W-1:0] rand_prio();
        logic signed [PRIO_W-1:0] p;
        case ($urandom_range(0, 3))
            0: p = $urandom();
            1: begin
                p = $urandom_range(0, 6);
                p = p - 3;
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: p = PRIO_MIN;
                    1: p = PRIO_MAX;
                    2: p = PRIO_MIN + 1;
                    default: p = PRIO_MAX - 1;
                endcase
            end
            default: begin
                // near a stored priority: equal, just above or just below
                if (pq_count != 0) begin
                    p = pq_prio[$urandom_range(0, pq_count - 1)];
                    p = p + $urandom_range(0, 4) - 2;
                end else begin
                    p = $urandom();
                end
            end
        endcase
        return p;
    endfunction

    function automatic logic [REQ_W-1:0] rand_req(input int unsigned enq_pct,
                                                  input int unsigned deq_pct);
        int unsigned        roll;
        logic [REQ_W-1:0]   req;
        roll = $urandom_range(0, 99);
        if (roll < enq_pct) begin
            req = REQ_ENQ;
        end else if (roll < enq_pct + deq_pct) begin
            req = REQ_DEQ;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 55)      req = REQ_CHG;
            else if (roll < 88) req = REQ_PEEK;
            else if (roll < 96) req = REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
            else                req = REQ_CLR;
        end
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Request side: one transaction per call, model updated on acceptance
    // ------------------------------------------------------------------
    task automatic send_req(input logic [REQ_W-1:0]         req,
                            input logic [TAG_PORT_W-1:0]    tag,
                            input logic signed [PRIO_W-1:0] prio);
        if (idling && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= req;
        i_item_tag      <= tag;
        i_item_priority <= prio;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        replies_due.push_back(pq_model_apply(req, tag, prio));
    endtask

    task automatic send_random(input int unsigned enq_pct, input int unsigned deq_pct);
        logic [REQ_W-1:0]           req;
        logic [TAG_PORT_W-1:0]      tag;
        logic signed [PRIO_W-1:0]   prio;
        req  = rand_req(enq_pct, deq_pct);
        tag  = rand_tag();
        prio = rand_prio();
        send_req(req, tag, prio);
    endtask

    // stop sending until every outstanding reply is back
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts, then score each transaction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || !idling) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= (stall_left > 1);
        end else if ($urandom_range(0, 9) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(1, 13);
        end
    end

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch %s: expected %h, got %h at %0t ns", what, want, got, $time);
        end
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                flag_mismatch("reply with nothing outstanding, tag", '0, o_out_tag);
            end else begin
                want = replies_due.pop_front();
                if (o_out_tag !== want.tag)
                    flag_mismatch("o_out_tag", want.tag, o_out_tag);
                if (o_out_priority !== want.prio)
                    flag_mismatch("o_out_priority", want.prio, o_out_priority);
                if (o_status !== want.status)
                    flag_mismatch("o_status", 32'(want.status), 32'(o_status));
                if (o_entry_count !== want.count)
                    flag_mismatch("o_entry_count", 32'(want.count), 32'(o_entry_count));
            end
        end
    end

    // Watchdog: a run that accepts no request and takes no result for too long is hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // peek, dequeue and change against an empty store
    task automatic test_empty_requests();
        send_req(REQ_PEEK, '0, '0);
        send_req(REQ_DEQ, TAG_ALL_ONES, PRIO_MIN);
        send_req(REQ_CHG, '0, '0);
    endtask

    // priority extremes, tag tiebreak and full tie (earliest wins)
    task automatic test_ordering_and_ties();
        send_req(REQ_ENQ, '0, PRIO_MAX);
        send_req(REQ_ENQ, TAG_ALL_ONES, PRIO_MIN);
        send_req(REQ_ENQ, 5, '0);
        send_req(REQ_ENQ, 3, '0);
        send_req(REQ_ENQ, 3, '0);
        send_req(REQ_ENQ, 9, PRIO_MIN);
        send_req(REQ_PEEK, '0, '0);
        send_req(REQ_DEQ, '0, '0);
        send_req(REQ_DEQ, '0, '0);
        send_req(REQ_DEQ, '0, '0);
    endtask

    // leaves 0/max, 5/0, 3/0 from the previous test
    task automatic test_change_priority();
        send_req(REQ_CHG, 5, '0);           // equal: not lower
        send_req(REQ_CHG, 5, 1);            // higher: not lower
        send_req(REQ_CHG, 3, -1);
        send_req(REQ_CHG, '0, PRIO_MIN);
        send_req(REQ_CHG, 77, -9);          // no such tag
        send_req(REQ_DEQ, '0, '0);
    endtask

    task automatic test_spare_codes_and_clear();
        for (int c = REQ_SPARE_FIRST; c <= REQ_SPARE_LAST; c++) begin
            send_req(REQ_W'(c), TAG_ALL_ONES, PRIO_MAX);
        end
        send_req(REQ_CLR, '0, '0);
        send_req(REQ_PEEK, '0, '0);
    endtask

    // fill past capacity (full status), then drain past empty
    task automatic test_fill_to_full();
        for (int round = 0; round < 2; round++) begin
            for (int n = 0; n < DEPTH + 2; n++) send_req(REQ_ENQ, rand_tag(), rand_prio());
            send_req(REQ_CHG, rand_tag(), rand_prio());
            send_req(REQ_PEEK, rand_tag(), rand_prio());
            for (int n = 0; n < DEPTH + 1; n++) send_req(REQ_DEQ, rand_tag(), rand_prio());
        end
    endtask

    // segments with growing, shrinking or balanced mixes; idling chosen at random per segment
    task automatic test_random_mix();
        int unsigned enq_pct;
        int unsigned deq_pct;
        for (int seg = 0; seg < 29; seg++) begin
            idling <= ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
                0: begin
                    enq_pct = 55;
                    deq_pct = 15;
                end
                1: begin
                    enq_pct = 20;
                    deq_pct = 55;
                end
                default: begin
                    enq_pct = 35;
                    deq_pct = 30;
                end
            endcase
            for (int n = 0; n < 50; n++) send_random(enq_pct, deq_pct);
            if (seg == 14) hold_until_drained();
        end
    endtask

    // closing stretch at full rate on both sides
    task automatic test_steady_stream();
        idling <= 1'b0;
        for (int n = 0; n < 190; n++) send_random(40, 30);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_requests();
        test_ordering_and_ties();
        test_change_priority();
        test_spare_codes_and_clear();
        idling <= 1'b1;
        test_fill_to_full();
        hold_until_drained();
        test_random_mix();
        test_steady_stream();

        i_in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
